// ===== sv/hmq_pkg.sv =====
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants of the binary max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hmq_pkg;

  localparam int unsigned HeapDepth = 1024;
  localparam int unsigned PrioW     = 16;
  localparam int unsigned PayW      = 32;
  localparam int unsigned AddrW     = $clog2(HeapDepth);
  localparam int unsigned CntW      = $clog2(HeapDepth + 1);
  // child indexes may run to about twice the count, so one extra bit
  localparam int unsigned IdxW      = CntW + 1;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_DN_RIGHT,
    S_DN_CMP,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  payload;
    status_e          status;
    logic [CntW-1:0]  entries;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/binary_max_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit
// Max-priority queue of 1024 entries kept as a binary heap in one RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. An insert reads the parent of the new slot, then
// climbs level by level in S_UP_CMP. An extract reads the root and the last
// entry, then sinks the moved entry level by level through S_DN_RIGHT and
// S_DN_CMP. Empty/full cases go straight to the result. The cost per level
// comes from the single RAM read port: sifting up needs one parent read per
// level, sifting down needs both children read in turn. The result then sits
// in an output register until taken, while the next job is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  output logic                              job_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [hmq_pkg::PrioW-1:0]    job_priority_i,
  input  wire logic [hmq_pkg::PayW-1:0]     job_payload_i,
  output logic                              res_valid_o,
  input  wire logic                         res_stall_i,
  output logic                              out_valid_o,
  output logic [hmq_pkg::PrioW-1:0]         out_priority_o,
  output logic [hmq_pkg::PayW-1:0]          out_payload_o,
  output logic [1:0]                        status_o,
  output logic [hmq_pkg::CntW-1:0]          entries_held_o
);

  logic                       ctl_res_valid;
  logic                       ctl_res_ready;
  hmq_pkg::result_t           ctl_res;
  logic                       ram_we;
  logic [hmq_pkg::AddrW-1:0]  ram_waddr;
  hmq_pkg::entry_t            ram_wdata;
  logic [hmq_pkg::AddrW-1:0]  ram_raddr;
  hmq_pkg::entry_t            ram_rdata;
  logic                       vld_q, vld_d;
  hmq_pkg::result_t           res_q, res_d;

  hmq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid_i),
    .job_stall_o    (job_stall_o),
    .opcode_i       (hmq_pkg::opcode_e'(opcode_i)),
    .job_priority_i (job_priority_i),
    .job_payload_i  (job_payload_i),
    .res_valid_o    (ctl_res_valid),
    .res_ready_i    (ctl_res_ready),
    .res_o          (ctl_res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  hmq_ram #(
    .Width ($bits(hmq_pkg::entry_t)),
    .Depth (hmq_pkg::HeapDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign ctl_res_ready = !vld_q || !res_stall_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (vld_q && !res_stall_i) begin
      vld_d = 1'b0;
    end
    if (ctl_res_valid && ctl_res_ready) begin
      vld_d = 1'b1;
      res_d = ctl_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o    = vld_q;
  assign out_valid_o    = res_q.found;
  assign out_priority_o = res_q.prio;
  assign out_payload_o  = res_q.payload;
  assign status_o       = res_q.status;
  assign entries_held_o = res_q.entries;

endmodule

`default_nettype wire

// ===== sv/hmq_ram.sv =====
// ----------------------------------------------------------------------------
// hmq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmq_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/hmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmq_ctrl
// Sequencer for insert (sift up) and extract (sift down) over the heap RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module hmq_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  output logic                              job_stall_o,
  input  wire hmq_pkg::opcode_e             opcode_i,
  input  wire logic [hmq_pkg::PrioW-1:0]    job_priority_i,
  input  wire logic [hmq_pkg::PayW-1:0]     job_payload_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output hmq_pkg::result_t                  res_o,
  output logic                              ram_we_o,
  output logic [hmq_pkg::AddrW-1:0]         ram_waddr_o,
  output hmq_pkg::entry_t                   ram_wdata_o,
  output logic [hmq_pkg::AddrW-1:0]         ram_raddr_o,
  input  wire hmq_pkg::entry_t              ram_rdata_i
);

  hmq_pkg::state_e                 state_q, state_d;
  logic [hmq_pkg::CntW-1:0]        count_q, count_d;
  logic [hmq_pkg::AddrW-1:0]       pos_q, pos_d;
  hmq_pkg::entry_t                 cur_q, cur_d;
  hmq_pkg::entry_t                 left_q, left_d;
  logic                            has_right_q, has_right_d;
  logic                            found_q, found_d;
  logic [hmq_pkg::PrioW-1:0]       oprio_q, oprio_d;
  logic [hmq_pkg::PayW-1:0]        opay_q, opay_d;
  hmq_pkg::status_e                status_q, status_d;

  logic                            job_acc;
  logic                            full;
  logic                            take_right;
  hmq_pkg::entry_t                 child;
  logic [hmq_pkg::AddrW-1:0]       child_idx;
  logic                            swap_dn;
  logic [hmq_pkg::AddrW-1:0]       dn_pos;
  logic [hmq_pkg::IdxW-1:0]        dn_left;
  logic                            dn_has_left;
  logic [hmq_pkg::IdxW-1:0]        rgt;
  logic [hmq_pkg::AddrW-1:0]       par, par2;
  logic                            swap_up;
  logic [hmq_pkg::CntW-1:0]        count_m1;

  assign job_acc     = job_valid_i && (state_q == hmq_pkg::S_IDLE);
  assign job_stall_o = (state_q != hmq_pkg::S_IDLE);
  assign full        = (count_q == hmq_pkg::CntW'(hmq_pkg::HeapDepth));
  assign count_m1    = count_q - 1'b1;

  // sift down: pick the larger child, left wins a tie
  assign take_right = has_right_q && (ram_rdata_i.prio > left_q.prio);
  assign child      = take_right ? ram_rdata_i : left_q;
  assign child_idx  = hmq_pkg::AddrW'({pos_q, 1'b1}) + hmq_pkg::AddrW'(take_right);
  assign swap_dn    = (cur_q.prio < child.prio);

  // position the next descent step starts from
  assign dn_pos      = (state_q == hmq_pkg::S_DN_CMP) ? child_idx : pos_q;
  assign dn_left     = hmq_pkg::IdxW'({dn_pos, 1'b1});
  assign dn_has_left = (dn_left < hmq_pkg::IdxW'(count_q));
  assign rgt         = hmq_pkg::IdxW'({pos_q, 1'b1}) + 1'b1;

  // sift up
  assign par     = (pos_q - 1'b1) >> 1;
  assign par2    = (par - 1'b1) >> 1;
  assign swap_up = (ram_rdata_i.prio < cur_q.prio);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hmq_pkg::S_IDLE: begin
        if (job_acc) begin
          if (opcode_i == hmq_pkg::OP_INSERT) begin
            if (full)                state_d = hmq_pkg::S_DONE;
            else if (count_q == '0)  state_d = hmq_pkg::S_FIN;
            else                     state_d = hmq_pkg::S_UP_CMP;
          end else begin
            if (count_q == '0)       state_d = hmq_pkg::S_DONE;
            else                     state_d = hmq_pkg::S_EX_ROOT;
          end
        end
      end
      hmq_pkg::S_EX_ROOT:  state_d = hmq_pkg::S_EX_LAST;
      hmq_pkg::S_EX_LAST: begin
        if (count_q == '0)   state_d = hmq_pkg::S_DONE;
        else if (dn_has_left) state_d = hmq_pkg::S_DN_RIGHT;
        else                 state_d = hmq_pkg::S_FIN;
      end
      hmq_pkg::S_DN_RIGHT: state_d = hmq_pkg::S_DN_CMP;
      hmq_pkg::S_DN_CMP: begin
        if (!swap_dn)         state_d = hmq_pkg::S_DONE;
        else if (dn_has_left) state_d = hmq_pkg::S_DN_RIGHT;
        else                  state_d = hmq_pkg::S_FIN;
      end
      hmq_pkg::S_UP_CMP: begin
        if (!swap_up)         state_d = hmq_pkg::S_DONE;
        else if (par == '0)   state_d = hmq_pkg::S_FIN;
        else                  state_d = hmq_pkg::S_UP_CMP;
      end
      hmq_pkg::S_FIN:      state_d = hmq_pkg::S_DONE;
      hmq_pkg::S_DONE: begin
        if (res_ready_i) state_d = hmq_pkg::S_IDLE;
      end
      default:             state_d = hmq_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    left_d      = left_q;
    has_right_d = has_right_q;
    found_d     = found_q;
    oprio_d     = oprio_q;
    opay_d      = opay_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = cur_q;
    ram_raddr_o = dn_left[hmq_pkg::AddrW-1:0];
    res_valid_o = 1'b0;
    unique case (state_q)
      hmq_pkg::S_IDLE: begin
        if (job_acc) begin
          found_d      = 1'b0;
          oprio_d      = '0;
          opay_d       = '0;
          status_d     = hmq_pkg::ST_OK;
          cur_d.prio    = job_priority_i;
          cur_d.payload = job_payload_i;
          if (opcode_i == hmq_pkg::OP_INSERT) begin
            if (full) begin
              status_d = hmq_pkg::ST_FULL;
            end else begin
              pos_d       = count_q[hmq_pkg::AddrW-1:0];
              count_d     = count_q + 1'b1;
              ram_raddr_o = hmq_pkg::AddrW'(count_m1 >> 1);
            end
          end else begin
            if (count_q == '0) begin
              status_d = hmq_pkg::ST_EMPTY;
            end else begin
              found_d     = 1'b1;
              pos_d       = '0;
              ram_raddr_o = '0;
            end
          end
        end
      end
      hmq_pkg::S_EX_ROOT: begin
        oprio_d     = ram_rdata_i.prio;
        opay_d      = ram_rdata_i.payload;
        count_d     = count_m1;
        ram_raddr_o = count_m1[hmq_pkg::AddrW-1:0];
      end
      hmq_pkg::S_EX_LAST: begin
        cur_d = ram_rdata_i;
      end
      hmq_pkg::S_DN_RIGHT: begin
        left_d      = ram_rdata_i;
        has_right_d = (rgt < hmq_pkg::IdxW'(count_q));
        ram_raddr_o = rgt[hmq_pkg::AddrW-1:0];
      end
      hmq_pkg::S_DN_CMP: begin
        ram_we_o = 1'b1;
        if (swap_dn) begin
          ram_wdata_o = child;
          pos_d       = child_idx;
        end
      end
      hmq_pkg::S_UP_CMP: begin
        ram_we_o    = 1'b1;
        ram_raddr_o = par2;
        if (swap_up) begin
          ram_wdata_o = ram_rdata_i;
          pos_d       = par;
        end
      end
      hmq_pkg::S_FIN: begin
        ram_we_o = 1'b1;
      end
      hmq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o.found   = found_q;
  assign res_o.prio    = oprio_q;
  assign res_o.payload = opay_q;
  assign res_o.status  = status_q;
  assign res_o.entries = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hmq_pkg::S_IDLE;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    has_right_q <= has_right_d;
    found_q     <= found_d;
    oprio_q     <= oprio_d;
    opay_q      <= opay_d;
    status_q    <= status_d;
  end

endmodule

`default_nettype wire
